// ===== sv/sgi_pkg.sv =====
// sgi_pkg: shared constants and types for the sample gap interpolator
// used by sgi_muldiv and sample_gap_interpolator; no dependencies
package sgi_pkg;

    // shared arithmetic unit datapath
    localparam int MD_W    = 72;                  // numerator / product width
    localparam int MD_DW   = 64;                  // divisor / multiplier operand width
    localparam int MUL_W   = 32;                  // multiplier bits consumed by a multiply
    localparam int MD_CW   = $clog2(MD_W + 1);    // step counter width

    // interpolation limit
    localparam int MAX_FILL = 16;
    localparam int CNT_W    = $clog2(MAX_FILL + 1);

    // time constants
    localparam logic [MD_W-1:0]  NS_PER_SEC = MD_W'(1000000000);
    localparam logic [MD_W-1:0]  NS_PER_MS  = MD_W'(1000000);
    localparam logic [MD_W-1:0]  NS_PER_US  = MD_W'(1000);

    // configuration register indexes
    localparam logic [2:0] CFG_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_VAL_MIN = 3'd1;
    localparam logic [2:0] CFG_VAL_MAX = 3'd2;
    localparam logic [2:0] CFG_MIN_GAP = 3'd3;
    localparam logic [2:0] CFG_WAKEUP  = 3'd4;

    // arithmetic unit operations
    localparam logic MD_OP_MUL = 1'b0;
    localparam logic MD_OP_DIV = 1'b1;

    typedef struct packed {
        logic              start;
        logic              op;
        logic [MD_W-1:0]   a;     // multiplicand or numerator
        logic [MD_DW-1:0]  b;     // multiplier (low bits) or divisor
    } t_md_req;

    typedef struct packed {
        logic              done;
        logic [MD_W-1:0]   res;   // product or quotient
        logic [MD_DW-1:0]  rem;   // remainder
    } t_md_rsp;

endpackage

// ===== sv/sgi_muldiv.sv =====
// sgi_muldiv: shared shift-add multiplier and restoring divider, one bit per cycle
// depends on sgi_pkg
module sgi_muldiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sgi_pkg::t_md_req i_req,
    output sgi_pkg::t_md_rsp o_rsp
);
    import sgi_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_op;
    logic [MD_CW-1:0]  r_cnt;
    logic [MD_W-1:0]   r_acc;
    logic [MD_DW:0]    r_rem;
    logic [MD_W-1:0]   r_a;
    logic [MD_DW-1:0]  r_b;

    logic [MD_DW:0]    w_sh;
    logic              w_ge;

    assign w_sh = {r_rem[MD_DW-1:0], r_acc[MD_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_b});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_rem  <= '0;
                if (i_req.op == MD_OP_DIV) begin
                    r_cnt <= MD_CW'(MD_W);
                    r_acc <= i_req.a;
                end else begin
                    r_cnt <= MD_CW'(MUL_W);
                    r_acc <= '0;
                end
            end else if (r_busy) begin
                if (r_op == MD_OP_DIV) begin
                    if (w_ge) begin
                        r_rem <= w_sh - {1'b0, r_b};
                        r_acc <= {r_acc[MD_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_acc <= {r_acc[MD_W-2:0], 1'b0};
                    end
                end else begin
                    // msb first over the low multiplier bits
                    r_acc <= (r_acc << 1) + (r_b[MUL_W-1] ? r_a : '0);
                    r_b   <= r_b << 1;
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MD_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;
    assign o_rsp.rem  = r_rem[MD_DW-1:0];

endmodule

// ===== sv/sample_gap_interpolator.sv =====
// sample_gap_interpolator: top level, sequencer around one shared multiply/divide unit
// depends on sgi_pkg and sgi_muldiv
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_func, i_fill_gaps, i_sample_*, i_stamp_*
//  result    out        o_valid / i_ready         o_out_*, o_synthetic, o_last_of_run
//  config    in         i_cfg_wr_en (no wait)     i_cfg_index, i_cfg_data
//
// one transaction at a time: o_ready is high only in idle
// each multiply or divide step issues one request to the shared unit and waits for done;
// a plain sample runs the time and threshold steps before its drop checks
// a fill run adds period, count, step and gap setup, then per interpolated sample
// a time split and three axis multiply/divide pairs, MAX_FILL samples when capped
// a stalled result holds the sequencer; the result register keeps the last
// surviving candidate so its last_of_run flag is known before it is shown
// reset (synchronous, active low) clears history, config and control state
module sample_gap_interpolator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_func,
    input  logic        i_fill_gaps,
    input  logic signed [15:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic signed [15:0] i_sample_z,
    input  logic [31:0] i_stamp_sec,
    input  logic [29:0] i_stamp_nsec,
    // result transactions
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic [31:0] o_out_sec,
    output logic [29:0] o_out_nsec,
    output logic        o_synthetic,
    output logic        o_last_of_run,
    // configuration writes
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import sgi_pkg::*;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TNOW = 5'd1;   // sample time in ns
    localparam logic [4:0] S_THR  = 5'd2;   // wakeup threshold in ns
    localparam logic [4:0] S_PER  = 5'd3;   // period in ns
    localparam logic [4:0] S_QDIV = 5'd4;   // rounded periods in the gap
    localparam logic [4:0] S_SDM  = 5'd5;   // (count + 1) * 1000
    localparam logic [4:0] S_STEP = 5'd6;   // step in us
    localparam logic [4:0] S_GUS  = 5'd7;   // gap in us
    localparam logic [4:0] S_SNS  = 5'd8;   // step in ns
    localparam logic [4:0] S_TDIV = 5'd9;   // split candidate time
    localparam logic [4:0] S_AXM  = 5'd10;  // |diff| * m
    localparam logic [4:0] S_AXD  = 5'd11;  // / gap_us
    localparam logic [4:0] S_EVAL = 5'd12;  // drop checks
    localparam logic [4:0] S_OUT  = 5'd13;  // push older result, not last
    localparam logic [4:0] S_NEXT = 5'd14;
    localparam logic [4:0] S_REAL = 5'd15;  // load the real sample as candidate
    localparam logic [4:0] S_FIN  = 5'd16;  // push final result

    // configuration
    logic [15:0]        r_period;
    logic signed [15:0] r_vmin;
    logic signed [15:0] r_vmax;
    logic [15:0]        r_min_gap;
    logic               r_wakeup;

    // history
    logic signed [15:0] r_last [3];
    logic [63:0]        r_told;

    // latched input transaction
    logic               r_fill;
    logic signed [15:0] r_smp [3];
    logic [31:0]        r_sec;
    logic [29:0]        r_nsec;

    // run working registers
    logic [4:0]         r_state;
    logic               r_issued;
    logic [63:0]        r_tnow;
    logic [25:0]        r_thr;
    logic [63:0]        r_gap;
    logic [35:0]        r_per;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_k;
    logic [15:0]        r_sd;
    logic [53:0]        r_step_us;
    logic [53:0]        r_gap_us;
    logic [63:0]        r_step_ns;
    logic [53:0]        r_m;
    logic [63:0]        r_t;
    logic signed [15:0] r_o [3];
    logic [16:0]        r_ad [3];
    logic               r_neg [3];
    logic [1:0]         r_axis;
    logic [MD_W-1:0]    r_prod;

    // candidate
    logic signed [16:0] r_cand [3];
    logic [31:0]        r_csec;
    logic [29:0]        r_cnsec;
    logic               r_syn;

    // result register
    logic               r_have;
    logic signed [15:0] r_out [3];
    logic [31:0]        r_out_sec;
    logic [29:0]        r_out_nsec;
    logic               r_out_syn;

    t_md_req            w_req;
    t_md_rsp            w_rsp;
    logic               w_calc;
    logic [63:0]        w_ct;
    logic [63:0]        w_dlt;
    logic               w_pass;
    logic signed [15:0] w_clamp [3];
    logic signed [16:0] w_d [3];
    logic [16:0]        w_q;
    logic signed [16:0] w_qs;
    logic               w_do_fill;

    function automatic logic signed [15:0] clamp16(input logic signed [16:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
        logic signed [16:0] lo17;
        logic signed [16:0] hi17;
        lo17 = {lo[15], lo};
        hi17 = {hi[15], hi};
        if (v < lo17) begin
            clamp16 = lo;
        end else if (v > hi17) begin
            clamp16 = hi;
        end else begin
            clamp16 = v[15:0];
        end
    endfunction

    sgi_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // operand selection for the shared unit
    always_comb begin
        w_calc = 1'b1;
        w_req.op = MD_OP_MUL;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            S_TNOW: begin
                w_req.a = NS_PER_SEC;
                w_req.b = MD_DW'(r_sec);
            end
            S_THR: begin
                w_req.a = NS_PER_US;
                w_req.b = MD_DW'(r_min_gap);
            end
            S_PER: begin
                w_req.a = NS_PER_MS;
                w_req.b = (r_period == 16'd0) ? MD_DW'(1) : MD_DW'(r_period);
            end
            S_QDIV: begin
                w_req.op = MD_OP_DIV;
                w_req.a  = MD_W'(r_gap + 64'(r_per >> 1));
                w_req.b  = MD_DW'(r_per);
            end
            S_SDM: begin
                w_req.a = NS_PER_US;
                w_req.b = MD_DW'(r_cnt) + MD_DW'(1);
            end
            S_STEP: begin
                w_req.op = MD_OP_DIV;
                w_req.a  = MD_W'(r_gap);
                w_req.b  = MD_DW'(r_sd);
            end
            S_GUS: begin
                w_req.op = MD_OP_DIV;
                w_req.a  = MD_W'(r_gap);
                w_req.b  = NS_PER_US[MD_DW-1:0];
            end
            S_SNS: begin
                w_req.a = MD_W'(r_step_us);
                w_req.b = MD_DW'(1000);
            end
            S_TDIV: begin
                w_req.op = MD_OP_DIV;
                w_req.a  = MD_W'(r_t);
                w_req.b  = NS_PER_SEC[MD_DW-1:0];
            end
            S_AXM: begin
                w_req.a = MD_W'(r_m);
                w_req.b = MD_DW'(r_ad[r_axis]);
            end
            S_AXD: begin
                w_req.op = MD_OP_DIV;
                w_req.a  = r_prod;
                w_req.b  = MD_DW'(r_gap_us);
            end
            default: begin
                w_calc = 1'b0;
            end
        endcase
        w_req.start = w_calc && !r_issued;
    end

    // drop checks against the current history
    always_comb begin
        w_ct   = r_syn ? r_t : r_tnow;
        w_dlt  = w_ct - r_told;
        w_pass = (w_ct > r_told) && !(r_wakeup && (w_dlt <= 64'(r_thr)));
        for (int i = 0; i < 3; i++) begin
            w_clamp[i] = clamp16(r_cand[i], r_vmin, r_vmax);
            w_d[i]     = 17'(r_smp[i]) - 17'(r_last[i]);
        end
        w_q  = w_rsp.res[16:0];
        w_qs = r_neg[r_axis] ? -$signed(w_q) : $signed(w_q);
        w_do_fill = r_fill && (r_told != 64'd0) && (r_tnow > r_told);
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 16'd200;
            r_vmin    <= -16'sd32768;
            r_vmax    <= 16'sd32767;
            r_min_gap <= 16'd0;
            r_wakeup  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PERIOD:  r_period  <= i_cfg_data;
                CFG_VAL_MIN: r_vmin    <= i_cfg_data;
                CFG_VAL_MAX: r_vmax    <= i_cfg_data;
                CFG_MIN_GAP: r_min_gap <= i_cfg_data;
                CFG_WAKEUP:  r_wakeup  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_have   <= 1'b0;
            r_told   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_rsp.done) begin
                r_issued <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_func) begin
                            // clear command: history back to zero, no result
                            r_told <= '0;
                            for (int i = 0; i < 3; i++) begin
                                r_last[i] <= '0;
                            end
                        end else begin
                            r_fill   <= i_fill_gaps;
                            r_smp[0] <= i_sample_x;
                            r_smp[1] <= i_sample_y;
                            r_smp[2] <= i_sample_z;
                            r_sec    <= i_stamp_sec;
                            r_nsec   <= i_stamp_nsec;
                            r_state  <= S_TNOW;
                        end
                    end
                end
                S_TNOW: begin
                    if (w_rsp.done) begin
                        r_tnow  <= w_rsp.res[63:0] + 64'(r_nsec);
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    if (w_rsp.done) begin
                        r_thr <= w_rsp.res[25:0];
                        if (w_do_fill) begin
                            r_gap <= r_tnow - r_told;
                            for (int i = 0; i < 3; i++) begin
                                r_o[i]   <= r_last[i];
                                r_neg[i] <= w_d[i][16];
                                r_ad[i]  <= w_d[i][16] ? 17'(-w_d[i]) : 17'(w_d[i]);
                            end
                            r_state <= S_PER;
                        end else begin
                            r_state <= S_REAL;
                        end
                    end
                end
                S_PER: begin
                    if (w_rsp.done) begin
                        r_per   <= w_rsp.res[35:0];
                        r_state <= S_QDIV;
                    end
                end
                S_QDIV: begin
                    if (w_rsp.done) begin
                        if (w_rsp.res > MD_W'(1)) begin
                            if (w_rsp.res > MD_W'(MAX_FILL)) begin
                                r_cnt <= CNT_W'(MAX_FILL);
                            end else begin
                                r_cnt <= w_rsp.res[CNT_W-1:0] - 1'b1;
                            end
                            r_state <= S_SDM;
                        end else begin
                            r_state <= S_REAL;
                        end
                    end
                end
                S_SDM: begin
                    if (w_rsp.done) begin
                        r_sd    <= w_rsp.res[15:0];
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_rsp.done) begin
                        r_step_us <= w_rsp.res[53:0];
                        r_state   <= S_GUS;
                    end
                end
                S_GUS: begin
                    if (w_rsp.done) begin
                        r_gap_us <= w_rsp.res[53:0];
                        r_state  <= S_SNS;
                    end
                end
                S_SNS: begin
                    if (w_rsp.done) begin
                        r_step_ns <= w_rsp.res[63:0];
                        r_t       <= r_told + w_rsp.res[63:0];
                        r_m       <= r_step_us;
                        r_k       <= CNT_W'(1);
                        r_syn     <= 1'b1;
                        r_state   <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (w_rsp.done) begin
                        r_csec  <= w_rsp.res[31:0];
                        r_cnsec <= w_rsp.rem[29:0];
                        r_axis  <= 2'd0;
                        r_state <= S_AXM;
                    end
                end
                S_AXM: begin
                    if (w_rsp.done) begin
                        r_prod  <= w_rsp.res;
                        r_state <= S_AXD;
                    end
                end
                S_AXD: begin
                    if (w_rsp.done) begin
                        r_cand[r_axis] <= 17'(r_o[r_axis]) + w_qs;
                        if (r_axis == 2'd2) begin
                            r_state <= S_EVAL;
                        end else begin
                            r_axis  <= r_axis + 2'd1;
                            r_state <= S_AXM;
                        end
                    end
                end
                S_REAL: begin
                    for (int i = 0; i < 3; i++) begin
                        r_cand[i] <= 17'(r_smp[i]);
                    end
                    r_csec  <= r_sec;
                    r_cnsec <= r_nsec;
                    r_syn   <= 1'b0;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_pass) begin
                        if (r_have) begin
                            r_state <= S_OUT;
                        end else begin
                            r_have     <= 1'b1;
                            r_out_sec  <= r_csec;
                            r_out_nsec <= r_cnsec;
                            r_out_syn  <= r_syn;
                            r_told     <= w_ct;
                            for (int i = 0; i < 3; i++) begin
                                r_out[i]  <= w_clamp[i];
                                r_last[i] <= w_clamp[i];
                            end
                            r_state <= S_NEXT;
                        end
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_OUT: begin
                    // older result leaves, the new candidate takes its place
                    if (i_ready) begin
                        r_out_sec  <= r_csec;
                        r_out_nsec <= r_cnsec;
                        r_out_syn  <= r_syn;
                        r_told     <= w_ct;
                        for (int i = 0; i < 3; i++) begin
                            r_out[i]  <= w_clamp[i];
                            r_last[i] <= w_clamp[i];
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_syn && (r_k != r_cnt)) begin
                        r_k     <= r_k + 1'b1;
                        r_m     <= r_m + r_step_us;
                        r_t     <= r_t + r_step_ns;
                        r_state <= S_TDIV;
                    end else if (r_syn) begin
                        r_state <= S_REAL;
                    end else if (r_have) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (i_ready) begin
                        r_have  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT) || (r_state == S_FIN);
    assign o_out_x       = r_out[0];
    assign o_out_y       = r_out[1];
    assign o_out_z       = r_out[2];
    assign o_out_sec     = r_out_sec;
    assign o_out_nsec    = r_out_nsec;
    assign o_synthetic   = r_out_syn;
    assign o_last_of_run = (r_state == S_FIN);

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for sample_gap_interpolator
// depends on sgi_pkg and the sample_gap_interpolator rtl; drives sample and clear
// transactions, predicts the emitted samples and compares them in order
module tb_top;
    import sgi_pkg::*;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;
    localparam longint unsigned NS_SEC = 64'd1000000000;
    localparam longint unsigned NS_MS  = 64'd1000000;
    localparam longint unsigned NS_USEC = 64'd1000;
    // worst quiet time of the sequencer after an item with no emission
    localparam int SETTLE_CYCLES = 8000;

    typedef struct {
        logic        func;
        logic        fill;
        logic [15:0] x, y, z;
        logic [31:0] sec;
        logic [29:0] nsec;
    } t_sample;

    typedef struct packed {
        logic [15:0] x, y, z;
        logic [31:0] sec;
        logic [29:0] nsec;
        logic        synth;
        logic        last;
    } t_emission;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_func = 1'b0;
    logic        i_fill_gaps = 1'b0;
    logic signed [15:0] i_sample_x = '0, i_sample_y = '0, i_sample_z = '0;
    logic [31:0] i_stamp_sec = '0;
    logic [29:0] i_stamp_nsec = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic signed [15:0] o_out_x, o_out_y, o_out_z;
    logic [31:0] o_out_sec;
    logic [29:0] o_out_nsec;
    logic        o_synthetic, o_last_of_run;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    sample_gap_interpolator dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers and the sample history
    int unsigned     m_period;
    int              m_vmin, m_vmax;
    int unsigned     m_min_gap;
    bit              m_wakeup;
    int              hist_x, hist_y, hist_z;
    logic [31:0]     hist_sec;
    logic [29:0]     hist_nsec;

    t_sample         samples_todo[$];
    t_emission       pending_emissions[$];
    t_sample         shown;
    bit              hold_input = 1'b0;
    int              errors = 0;
    longint unsigned cycle_cnt = 0;
    longint unsigned now_ns;

    // long calm window: no idling on either side
    wire calm = (cycle_cnt % 200000) < 40000;

    task automatic report(input string msg);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    function automatic longint unsigned to_ns(logic [31:0] s, logic [29:0] n);
        return longint'(s) * NS_SEC + longint'(n);
    endfunction

    function automatic int clamp_axis(int v);
        if (v < m_vmin) return m_vmin;
        if (v > m_vmax) return m_vmax;
        return v;
    endfunction

    // one candidate: drop on stale time or wakeup gap, else clamp and record
    function automatic void offer(int x, int y, int z, logic [31:0] s, logic [29:0] n,
                                  bit synth);
        longint unsigned t, told;
        t_emission e;
        t = to_ns(s, n);
        told = to_ns(hist_sec, hist_nsec);
        if (t <= told) return;
        if (m_wakeup && (t - told) <= longint'(m_min_gap) * NS_USEC) return;
        hist_x = clamp_axis(x);
        hist_y = clamp_axis(y);
        hist_z = clamp_axis(z);
        hist_sec = s;
        hist_nsec = n;
        e.x = hist_x[15:0];
        e.y = hist_y[15:0];
        e.z = hist_z[15:0];
        e.sec = s;
        e.nsec = n;
        e.synth = synth;
        e.last = 1'b0;
        pending_emissions.push_back(e);
    endfunction

    // axis step toward the new sample, truncated toward zero
    function automatic int lerp(int base, int diff, longint unsigned m,
                                longint unsigned gap_us);
        logic [127:0] prod;
        int q;
        prod = 128'(diff < 0 ? -diff : diff) * 128'(m);
        q = int'(prod / 128'(gap_us));
        return base + (diff < 0 ? -q : q);
    endfunction

    function automatic void predict_emissions(t_sample it);
        int sx, sy, sz, n_prior;
        longint unsigned told, tnow, gap, per, q, cnt, step_us, gap_us, m, t;
        if (it.func == FUNC_CLEAR) begin
            hist_x = 0; hist_y = 0; hist_z = 0;
            hist_sec = '0; hist_nsec = '0;
            return;
        end
        sx = int'($signed(it.x));
        sy = int'($signed(it.y));
        sz = int'($signed(it.z));
        n_prior = pending_emissions.size();
        told = to_ns(hist_sec, hist_nsec);
        tnow = to_ns(it.sec, it.nsec);
        if (it.fill && told != 0 && tnow > told) begin
            gap = tnow - told;
            per = longint'(m_period == 0 ? 1 : m_period) * NS_MS;
            q = (gap + per / 2) / per;
            if (q > 1) begin
                int ox, oy, oz;
                ox = hist_x; oy = hist_y; oz = hist_z;
                cnt = q - 1;
                if (cnt > MAX_FILL) cnt = MAX_FILL;
                step_us = gap / (cnt + 1) / NS_USEC;
                gap_us = gap / NS_USEC;
                for (longint unsigned k = 1; k <= cnt; k++) begin
                    m = step_us * k;
                    t = told + m * NS_USEC;
                    offer(lerp(ox, sx - ox, m, gap_us), lerp(oy, sy - oy, m, gap_us),
                          lerp(oz, sz - oz, m, gap_us),
                          32'(t / NS_SEC), 30'(t % NS_SEC), 1'b1);
                end
            end
        end
        offer(sx, sy, sz, it.sec, it.nsec, 1'b0);
        if (pending_emissions.size() > n_prior)
            pending_emissions[pending_emissions.size() - 1].last = 1'b1;
    endfunction

    // driver: one item per handshake, random gaps
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                predict_emissions(shown);
            if (!i_valid || o_ready) begin
                if (!hold_input && samples_todo.size() > 0 &&
                    (calm || $urandom_range(0, 99) >= 36)) begin
                    shown = samples_todo.pop_front();
                    i_func <= shown.func;
                    i_fill_gaps <= shown.fill;
                    i_sample_x <= shown.x;
                    i_sample_y <= shown.y;
                    i_sample_z <= shown.z;
                    i_stamp_sec <= shown.sec;
                    i_stamp_nsec <= shown.nsec;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each emission against the oldest prediction
    always @(posedge i_clk) begin
        t_emission got;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_out_x, o_out_y, o_out_z, o_out_sec, o_out_nsec,
                       o_synthetic, o_last_of_run};
                if (pending_emissions.size() == 0)
                    report($sformatf("unexpected emission %h", got));
                else if (got !== pending_emissions[0])
                    report($sformatf("got %h want %h", got, pending_emissions.pop_front()));
                else
                    void'(pending_emissions.pop_front());
            end
            i_ready <= calm || $urandom_range(0, 99) >= 36;
        end
    end

    function automatic t_sample mk(logic f, logic fill, int x, int y, int z,
                                   longint unsigned t);
        t_sample it;
        it.func = f; it.fill = fill;
        it.x = x[15:0]; it.y = y[15:0]; it.z = z[15:0];
        it.sec = 32'(t / NS_SEC);
        it.nsec = 30'(t % NS_SEC);
        return it;
    endfunction

    function automatic int rnd_axis(int near);
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2, 3: return int'($signed(16'($urandom)));
            default: return near + $urandom_range(0, 4000) - 2000;
        endcase
    endfunction

    // random item: mostly steady forward samples, some clears, stale and wild times
    task automatic queue_random(int count);
        t_sample it;
        longint unsigned per, gap;
        int r, vx, vy, vz;
        vx = 0; vy = 0; vz = 0;
        repeat (count) begin
            per = longint'(m_period == 0 ? 1 : m_period) * NS_MS;
            r = $urandom_range(0, 99);
            vx = rnd_axis(vx); vy = rnd_axis(vy); vz = rnd_axis(vz);
            if (vx > 32767) vx = 32767; if (vx < -32768) vx = -32768;
            if (vy > 32767) vy = 32767; if (vy < -32768) vy = -32768;
            if (vz > 32767) vz = 32767; if (vz < -32768) vz = -32768;
            if (r < 6) begin
                it = mk(FUNC_CLEAR, 1'($urandom_range(0, 1)), vx, vy, vz, now_ns);
                it.x = 16'($urandom); it.sec = $urandom;
            end else if (r < 13) begin
                // stale or equal time
                it = mk(FUNC_SAMPLE, 1'($urandom_range(0, 1)), vx, vy, vz,
                        now_ns - longint'($urandom_range(0, 3)) * per / 2);
            end else if (r < 17) begin
                // wild time anywhere in range, then start over from a clear
                it = mk(FUNC_SAMPLE, 1'b1, vx, vy, vz, 0);
                it.sec = $urandom;
                it.nsec = 30'($urandom_range(0, 30'h3fffffff));
                samples_todo.push_back(it);
                it = mk(FUNC_CLEAR, 1'b0, 0, 0, 0, 0);
            end else begin
                if ($urandom_range(0, 99) < 8)
                    gap = per * $urandom_range(5, 20);
                else if ($urandom_range(0, 99) < 5)
                    gap = per * $urandom_range(50, 200);
                else
                    gap = per * $urandom_range(0, 3);
                gap += longint'($urandom_range(0, 1000000)) * per / 1000000;
                now_ns += gap;
                it = mk(FUNC_SAMPLE, $urandom_range(0, 99) < 80, vx, vy, vz, now_ns);
                // same time written with nsec carrying a whole second
                if ($urandom_range(0, 9) == 0 && it.sec > 0 && it.nsec < 30'd73741823) begin
                    it.sec -= 1;
                    it.nsec += 30'd1000000000;
                end
            end
            samples_todo.push_back(it);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PERIOD:  m_period = val;
            CFG_VAL_MIN: m_vmin = int'($signed(val));
            CFG_VAL_MAX: m_vmax = int'($signed(val));
            CFG_MIN_GAP: m_min_gap = val;
            CFG_WAKEUP:  m_wakeup = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(int per, int vmin, int vmax, int gap, bit wake);
        write_reg(CFG_PERIOD, per[15:0]);
        write_reg(CFG_VAL_MIN, vmin[15:0]);
        write_reg(CFG_VAL_MAX, vmax[15:0]);
        write_reg(CFG_MIN_GAP, gap[15:0]);
        write_reg(CFG_WAKEUP, {15'd0, wake});
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // nothing queued, nothing shown, nothing outstanding; checked away from the edge
    task automatic wait_empty();
        do @(negedge i_clk);
        while (samples_todo.size() != 0 || i_valid || pending_emissions.size() != 0);
    endtask

    // block is idle: nothing queued, nothing shown, nothing outstanding
    task automatic drain();
        wait_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_sample it;
        longint unsigned t0;
        m_period = 200; m_vmin = -32768; m_vmax = 32767; m_min_gap = 0; m_wakeup = 0;
        hist_x = 0; hist_y = 0; hist_z = 0; hist_sec = '0; hist_nsec = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, 200 ms period
        t0 = 1000 * NS_SEC;
        samples_todo.push_back(mk(FUNC_CLEAR, 1'b0, 0, 0, 0, 0));
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 0, 0, 0, t0));        // no history yet
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 100, 5, -5, t0 + 200 * NS_MS));
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, -100, 32767, -32768,
                                  t0 + 600 * NS_MS));                     // one fill
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 32767, -32768, 0,
                                  t0 + 4600 * NS_MS));                    // fill capped
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 1, 1, 1, t0 + 4600 * NS_MS)); // same time
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b0, 2, 2, 2, t0 + 4000 * NS_MS)); // backward
        it = mk(FUNC_SAMPLE, 1'b1, -7, 9, 300, t0 + 5200 * NS_MS);
        it.sec -= 1; it.nsec += 30'd1000000000;                            // oversized nsec
        samples_todo.push_back(it);
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b0, 50, 60, 70, t0 + 6200 * NS_MS));
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, -50, -60, -70,
                                  t0 + 6680 * NS_MS));                    // rounds to two
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 9, 9, 9, t0 + 6978 * NS_MS));
        it = mk(FUNC_CLEAR, 1'b1, -1, -1, -1, t0);
        it.sec = '1; it.nsec = '1;
        samples_todo.push_back(it);
        samples_todo.push_back(mk(FUNC_SAMPLE, 1'b1, 3, -3, 3, 5));         // zero seconds
        it = mk(FUNC_SAMPLE, 1'b1, -32768, 32767, -1, 0);
        it.sec = 32'hffffffff; it.nsec = 30'd999999999;                    // latest time
        samples_todo.push_back(it);
        samples_todo.push_back(mk(FUNC_CLEAR, 1'b0, 0, 0, 0, 0));

        // hold the sender until every emission is out
        wait (samples_todo.size() == 0);
        hold_input = 1'b1;
        wait_empty();
        hold_input = 1'b0;
        now_ns = t0;
        queue_random(20);
        drain();

        set_config(1, -100, 100, 500, 1'b1);
        now_ns = 2000 * NS_SEC;
        queue_random(45);
        drain();

        // zero period counts as one millisecond, widest wakeup threshold
        set_config(0, -32768, 32767, 65535, 1'b1);
        queue_random(25);
        drain();

        // longest period with crossed clamp limits
        set_config(65535, 200, -200, 0, 1'b0);
        queue_random(25);
        drain();

        set_config(200, -32768, 32767, 0, 1'b0);
        queue_random(30);
        drain();

        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial begin
        #100000000;
        $display("tb_top: errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/sgi_pkg.sv
sv/sgi_muldiv.sv
sv/sample_gap_interpolator.sv
tb/tb_top.sv
